>>> rtl/tpm_pkg.sv
// tilt-to-pointer motion package: zone codes, configuration register map,
// register reset values and the configuration struct
// no dependencies
`default_nettype none

package tpm_pkg;

    // default widths of the sample and timestamp fields
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    // fixed field widths
    localparam int THRESH_BITS    = 15;
    localparam int SPEED_BITS     = 5;
    localparam int AGE_BITS       = 16;
    localparam int MOVE_BITS      = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // register map
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_ZONE        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLIGHT_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRONG_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLIGHT_SPEED     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRONG_SPEED     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_AFTER_MS  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIPLE_AFTER_MS  = 3'd6;

    // register reset values
    localparam logic [THRESH_BITS-1:0] DEAD_ZONE_RST        = 15'd1000;
    localparam logic [THRESH_BITS-1:0] SLIGHT_THRESHOLD_RST = 15'd3000;
    localparam logic [THRESH_BITS-1:0] STRONG_THRESHOLD_RST = 15'd8000;
    localparam logic [SPEED_BITS-1:0]  SLIGHT_SPEED_RST     = 5'd2;
    localparam logic [SPEED_BITS-1:0]  STRONG_SPEED_RST     = 5'd5;
    localparam logic [AGE_BITS-1:0]    DOUBLE_AFTER_MS_RST  = 16'd10;
    localparam logic [AGE_BITS-1:0]    TRIPLE_AFTER_MS_RST  = 16'd50;

    typedef enum logic [2:0] {
        ZONE_NEUTRAL    = 3'd0,
        ZONE_SLIGHT_NEG = 3'd1,
        ZONE_STRONG_NEG = 3'd2,
        ZONE_SLIGHT_POS = 3'd3,
        ZONE_STRONG_POS = 3'd4
    } zone_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] dead_zone;
        logic [THRESH_BITS-1:0] slight_threshold;
        logic [THRESH_BITS-1:0] strong_threshold;
        logic [SPEED_BITS-1:0]  slight_speed;
        logic [SPEED_BITS-1:0]  strong_speed;
        logic [AGE_BITS-1:0]    double_after_ms;
        logic [AGE_BITS-1:0]    triple_after_ms;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        dead_zone:        DEAD_ZONE_RST,
        slight_threshold: SLIGHT_THRESHOLD_RST,
        strong_threshold: STRONG_THRESHOLD_RST,
        slight_speed:     SLIGHT_SPEED_RST,
        strong_speed:     STRONG_SPEED_RST,
        double_after_ms:  DOUBLE_AFTER_MS_RST,
        triple_after_ms:  TRIPLE_AFTER_MS_RST
    };

endpackage

`default_nettype wire

>>> rtl/tpm_axis.sv
// one axis of the tilt-to-pointer motion block: zone sort, zone age tracking
// and step computation; holds the axis zone and its start time
// depends on tpm_pkg
`default_nettype none

module tpm_axis #(
    parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = tpm_pkg::TIME_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample,
    input  wire logic        [TIME_BITS-1:0]       now,
    input  wire tpm_pkg::cfg_t                     cfg,
    output logic signed      [tpm_pkg::MOVE_BITS-1:0] move
);

    import tpm_pkg::*;

    localparam int CMP_BITS  = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int PROD_BITS = SPEED_BITS + 2;

    zone_t                  zone_reg;
    zone_t                  zone_new;
    logic [TIME_BITS-1:0]   since_reg;
    logic [TIME_BITS-1:0]   age;
    logic [SAMPLE_BITS-1:0] mag;
    logic [CMP_BITS-1:0]    mag_ext;
    logic                   neg;
    logic                   changed;
    logic [1:0]             factor;
    logic [SPEED_BITS-1:0]  speed;
    logic [PROD_BITS-1:0]   total;

    // magnitude: the most negative sample maps to 2^(SAMPLE_BITS-1) unsigned
    always_comb
    begin
        neg     = sample[SAMPLE_BITS-1];
        mag     = neg ? SAMPLE_BITS'(~$unsigned(sample) + 1'b1) : $unsigned(sample);
        mag_ext = CMP_BITS'(mag);
    end

    // dead zone test first, then strong, then slight; below the dead zone is neutral
    always_comb
    begin
        priority if (mag_ext < CMP_BITS'(cfg.dead_zone))
            zone_new = ZONE_NEUTRAL;
        else if (mag_ext > CMP_BITS'(cfg.strong_threshold))
            zone_new = neg ? ZONE_STRONG_NEG : ZONE_STRONG_POS;
        else if (mag_ext > CMP_BITS'(cfg.slight_threshold))
            zone_new = neg ? ZONE_SLIGHT_NEG : ZONE_SLIGHT_POS;
        else
            zone_new = ZONE_NEUTRAL;
    end

    always_comb
    begin
        changed = (zone_new != zone_reg);
        // a fresh zone starts now, so its age is zero
        age     = changed ? '0 : TIME_BITS'(now - since_reg);

        priority if (age >= TIME_BITS'(cfg.triple_after_ms))
            factor = 2'd3;
        else if (age >= TIME_BITS'(cfg.double_after_ms))
            factor = 2'd2;
        else
            factor = 2'd1;

        speed = (zone_new == ZONE_SLIGHT_NEG || zone_new == ZONE_SLIGHT_POS)
                ? cfg.slight_speed : cfg.strong_speed;
        total = PROD_BITS'(factor) * PROD_BITS'(speed);

        unique case (zone_new)
            ZONE_SLIGHT_POS,
            ZONE_STRONG_POS: move = MOVE_BITS'(0) - MOVE_BITS'(total);
            ZONE_SLIGHT_NEG,
            ZONE_STRONG_NEG: move = MOVE_BITS'(total);
            default:         move = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg  <= ZONE_NEUTRAL;
            since_reg <= '0;
        end
        else if (step && changed)
        begin
            zone_reg  <= zone_new;
            since_reg <= now;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tilt_to_pointer_motion_core.sv
// Tilt-to-pointer motion core. Each transfer on the input channel carries an X and a
// Y accelerometer sample and a millisecond timestamp; each gives exactly one result
// transfer with a signed X and Y pointer step. Per axis the magnitude is sorted into
// neutral, slight or strong tilt, the zone's age sets a factor of 1, 2 or 3 on the
// configured speed, and positive tilt gives a negative step. The core takes one item
// per clock while in_stall is low: an input register feeds a single pass of compare
// and small-multiply logic into the result register, and a result is taken from
// there when the output is not stalled.
// A held result only stalls the input once the input register is also full.
// Configuration writes are always ready and must be made only while no item is in
// flight.
// depends on tpm_pkg and tpm_axis
`default_nettype none

module tilt_to_pointer_motion_core #(
    parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = tpm_pkg::TIME_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]         accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0]         accel_y,
    input  wire logic        [TIME_BITS-1:0]           now_ms,
    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed      [tpm_pkg::MOVE_BITS-1:0]  move_x,
    output logic signed      [tpm_pkg::MOVE_BITS-1:0]  move_y,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tpm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [tpm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    import tpm_pkg::*;

    cfg_t                          cfg_reg;
    cfg_t                          cfg_next;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [SAMPLE_BITS-1:0] accel_x_reg;
    logic signed [SAMPLE_BITS-1:0] accel_y_reg;
    logic        [TIME_BITS-1:0]   now_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [MOVE_BITS-1:0]   move_x_reg;
    logic signed [MOVE_BITS-1:0]   move_y_reg;
    logic signed [MOVE_BITS-1:0]   move_x_calc;
    logic signed [MOVE_BITS-1:0]   move_y_calc;

    logic                          advance;
    logic                          s1_step;
    logic                          in_xfer;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEAD_ZONE:        cfg_next.dead_zone        = cfg_data[THRESH_BITS-1:0];
                REG_SLIGHT_THRESHOLD: cfg_next.slight_threshold = cfg_data[THRESH_BITS-1:0];
                REG_STRONG_THRESHOLD: cfg_next.strong_threshold = cfg_data[THRESH_BITS-1:0];
                REG_SLIGHT_SPEED:     cfg_next.slight_speed     = cfg_data[SPEED_BITS-1:0];
                REG_STRONG_SPEED:     cfg_next.strong_speed     = cfg_data[SPEED_BITS-1:0];
                REG_DOUBLE_AFTER_MS:  cfg_next.double_after_ms  = cfg_data[AGE_BITS-1:0];
                REG_TRIPLE_AFTER_MS:  cfg_next.triple_after_ms  = cfg_data[AGE_BITS-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RST;
        else
            cfg_reg <= cfg_next;
    end

    // flow control: the result register moves when empty or being taken
    always_comb
    begin
        advance        = !out_valid_reg || !out_stall;
        s1_step        = s1_valid_reg && advance;
        in_stall       = s1_valid_reg && !advance;
        in_xfer        = in_valid && !in_stall;
        s1_valid_next  = in_xfer ? 1'b1 : (s1_step ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            accel_x_reg <= accel_x;
            accel_y_reg <= accel_y;
            now_reg     <= now_ms;
        end
        if (s1_step)
        begin
            move_x_reg <= move_x_calc;
            move_y_reg <= move_y_calc;
        end
    end

    tpm_axis #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_step),
        .sample (accel_x_reg),
        .now    (now_reg),
        .cfg    (cfg_reg),
        .move   (move_x_calc)
    );

    tpm_axis #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_step),
        .sample (accel_y_reg),
        .now    (now_reg),
        .cfg    (cfg_reg),
        .move   (move_y_calc)
    );

    assign out_valid = out_valid_reg;
    assign move_x    = move_x_reg;
    assign move_y    = move_y_reg;

endmodule

`default_nettype wire

>>> rtl/tpm_checker.sv
// port-level checks for the tilt-to-pointer motion core, attached by bind
// depends on tilt_to_pointer_motion_core and tpm_pkg
`default_nettype none

module tpm_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_stall,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic signed [tpm_pkg::MOVE_BITS-1:0] move_x,
    input wire logic signed [tpm_pkg::MOVE_BITS-1:0] move_y
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(move_x) && $stable(move_y))
        else $error("stalled result changed");

    // a result only goes away after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without a transfer");

    // the input side only backs up when a result is held at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output is free");

    // speed at most 31 times a factor of at most 3
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (move_x >= -8'sd93 && move_x <= 8'sd93
                       && move_y >= -8'sd93 && move_y <= 8'sd93))
        else $error("pointer step out of range");

endmodule

bind tilt_to_pointer_motion_core tpm_checker u_tpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .move_x    (move_x),
    .move_y    (move_y)
);

`default_nettype wire

>>> verif/tb_tilt_to_pointer_motion_core.sv
`timescale 1ns / 1ps
// self-checking testbench for tilt_to_pointer_motion_core: tracks each axis's zone and
// zone start time, predicts every pointer step and checks result transfers in order
// depends on tpm_pkg and the core rtl
module tb_tilt_to_pointer_motion_core;
    import tpm_pkg::*;

    localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
    localparam int STAMP_W     = TIME_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int AXIS_X      = 0;
    localparam int AXIS_Y      = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [MOVE_BITS-1:0] step_x;
        logic [MOVE_BITS-1:0] step_y;
    } move_pair_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic signed [SAMPLE_W-1:0]       accel_x   = '0;
    logic signed [SAMPLE_W-1:0]       accel_y   = '0;
    logic        [STAMP_W-1:0]        now_ms    = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic signed [MOVE_BITS-1:0]      move_x;
    logic signed [MOVE_BITS-1:0]      move_y;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic        [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic        [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // predictor state
    cfg_t               live_cfg;
    zone_t              axis_zone  [2];
    logic [STAMP_W-1:0] zone_start [2];
    move_pair_t         moves_due  [$];

    // stimulus state
    logic [SAMPLE_W-1:0] held [2];
    logic [STAMP_W-1:0]  stamp = '0;
    bit                  quiet = 1'b0;
    int                  hold_left = 0;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;

    tilt_to_pointer_motion_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .move_x    (move_x),
        .move_y    (move_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------ predictor

    function automatic zone_t classify_tilt(input logic [SAMPLE_W-1:0] smp);
        logic [SAMPLE_W:0] mag;
        // full-scale negative has a magnitude one beyond the positive range
        mag = smp[SAMPLE_W-1] ? ((1 << SAMPLE_W) - {1'b0, smp}) : {1'b0, smp};
        if (mag < {2'b00, live_cfg.dead_zone})
            return ZONE_NEUTRAL;
        if (mag > {2'b00, live_cfg.strong_threshold})
            return smp[SAMPLE_W-1] ? ZONE_STRONG_NEG : ZONE_STRONG_POS;
        if (mag > {2'b00, live_cfg.slight_threshold})
            return smp[SAMPLE_W-1] ? ZONE_SLIGHT_NEG : ZONE_SLIGHT_POS;
        return ZONE_NEUTRAL;
    endfunction

    function automatic logic [MOVE_BITS-1:0] axis_step(input int ax,
                                                       input logic [SAMPLE_W-1:0] smp,
                                                       input logic [STAMP_W-1:0] now);
        zone_t                z;
        logic [STAMP_W-1:0]   age;
        logic [MOVE_BITS-1:0] factor;
        logic [MOVE_BITS-1:0] speed;
        logic [MOVE_BITS-1:0] total;
        z = classify_tilt(smp);
        if (z != axis_zone[ax])
        begin
            axis_zone[ax]  = z;
            zone_start[ax] = now;
        end
        if (z == ZONE_NEUTRAL)
            return '0;
        age = now - zone_start[ax];
        if (age >= STAMP_W'(live_cfg.triple_after_ms))
            factor = 8'd3;
        else if (age >= STAMP_W'(live_cfg.double_after_ms))
            factor = 8'd2;
        else
            factor = 8'd1;
        if (z == ZONE_SLIGHT_NEG || z == ZONE_SLIGHT_POS)
            speed = MOVE_BITS'(live_cfg.slight_speed);
        else
            speed = MOVE_BITS'(live_cfg.strong_speed);
        total = factor * speed;
        // positive tilt moves the pointer the other way
        if (z == ZONE_SLIGHT_POS || z == ZONE_STRONG_POS)
            total = -total;
        return total;
    endfunction

    // ------------------------------------------------------------------ checking

    task automatic report_error(input string msg);
        if (mismatch_count < 100)
            $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_moves
        move_pair_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (moves_due.size() == 0)
                report_error($sformatf("result transfer %0d/%0d with nothing expected",
                                       move_x, move_y));
            else
            begin
                due = moves_due.pop_front();
                if (move_x !== due.step_x)
                    report_error($sformatf("move_x got %0d expected %0d",
                                           move_x, $signed(due.step_x)));
                if (move_y !== due.step_y)
                    report_error($sformatf("move_y got %0d expected %0d",
                                           move_y, $signed(due.step_y)));
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < 20);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[tilt_to_pointer_motion_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------ drivers

    task automatic send_sample(input logic [SAMPLE_W-1:0] sx,
                               input logic [SAMPLE_W-1:0] sy,
                               input logic [STAMP_W-1:0] now);
        move_pair_t due;
        if (!quiet && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= sx;
        accel_y  <= sy;
        now_ms   <= now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        due.step_x = axis_step(AXIS_X, sx, now);
        due.step_y = axis_step(AXIS_Y, sy, now);
        moves_due.push_back(due);
    endtask

    // drop valid in the step of the last transfer and let every result drain
    task automatic settle();
        in_valid <= 1'b0;
        while (moves_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_DEAD_ZONE:        live_cfg.dead_zone        = data[THRESH_BITS-1:0];
            REG_SLIGHT_THRESHOLD: live_cfg.slight_threshold = data[THRESH_BITS-1:0];
            REG_STRONG_THRESHOLD: live_cfg.strong_threshold = data[THRESH_BITS-1:0];
            REG_SLIGHT_SPEED:     live_cfg.slight_speed     = data[SPEED_BITS-1:0];
            REG_STRONG_SPEED:     live_cfg.strong_speed     = data[SPEED_BITS-1:0];
            REG_DOUBLE_AFTER_MS:  live_cfg.double_after_ms  = data[AGE_BITS-1:0];
            REG_TRIPLE_AFTER_MS:  live_cfg.triple_after_ms  = data[AGE_BITS-1:0];
            default: ;
        endcase
    endtask

    // unused upper data bits are filled at random, the core must mask them off
    task automatic load_settings(input cfg_t c);
        settle();
        write_reg(REG_DEAD_ZONE,        {1'($urandom), c.dead_zone});
        write_reg(REG_SLIGHT_THRESHOLD, {1'($urandom), c.slight_threshold});
        write_reg(REG_STRONG_THRESHOLD, {1'($urandom), c.strong_threshold});
        write_reg(REG_SLIGHT_SPEED,     {11'($urandom), c.slight_speed});
        write_reg(REG_STRONG_SPEED,     {11'($urandom), c.strong_speed});
        write_reg(REG_DOUBLE_AFTER_MS,  c.double_after_ms);
        write_reg(REG_TRIPLE_AFTER_MS,  c.triple_after_ms);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------ random stimulus

    function automatic int pick_field(input int width);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return 0;
        if (sel < 30)
            return (1 << width) - 1;
        return $urandom_range(0, (1 << width) - 1);
    endfunction

    function automatic cfg_t rand_settings(input bit ordered);
        cfg_t c;
        if (ordered)
        begin
            c.dead_zone        = 15'($urandom_range(0, 4000));
            c.slight_threshold = c.dead_zone + 15'($urandom_range(0, 8000));
            c.strong_threshold = c.slight_threshold + 15'($urandom_range(0, 16000));
            c.double_after_ms  = 16'($urandom_range(0, 100));
            c.triple_after_ms  = c.double_after_ms + 16'($urandom_range(0, 200));
        end
        else
        begin
            c.dead_zone        = 15'(pick_field(THRESH_BITS));
            c.slight_threshold = 15'(pick_field(THRESH_BITS));
            c.strong_threshold = 15'(pick_field(THRESH_BITS));
            c.double_after_ms  = 16'(pick_field(AGE_BITS));
            c.triple_after_ms  = 16'(pick_field(AGE_BITS));
        end
        c.slight_speed = 5'(pick_field(SPEED_BITS));
        c.strong_speed = 5'(pick_field(SPEED_BITS));
        return c;
    endfunction

    // mostly keep the axis in its zone so the age climbs, otherwise hit a threshold
    // edge or jump anywhere
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int ax);
        int sel;
        int mag;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return held[ax];
        if (sel < 80)
        begin
            case ($urandom_range(0, 2))
                0:       mag = int'(live_cfg.dead_zone);
                1:       mag = int'(live_cfg.slight_threshold);
                default: mag = int'(live_cfg.strong_threshold);
            endcase
            mag = mag + int'($urandom_range(0, 2)) - 1;
            if (mag < 0)
                mag = 0;
            if ($urandom_range(0, 1))
                held[ax] = SAMPLE_W'(-mag);
            else
                held[ax] = SAMPLE_W'((mag > 32767) ? 32767 : mag);
        end
        else
            held[ax] = SAMPLE_W'($urandom);
        return held[ax];
    endfunction

    function automatic void advance_stamp();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            stamp += $urandom_range(0, live_cfg.triple_after_ms / 4 + 2);
        else if (sel < 85)
            stamp += $urandom_range(0, 3);
        else if (sel < 95)
            stamp += $urandom_range(0, 131071);
        else
            stamp = $urandom;
    endfunction

    task automatic run_random(input int count);
        logic [SAMPLE_W-1:0] sx;
        logic [SAMPLE_W-1:0] sy;
        repeat (count)
        begin
            sx = pick_sample(AXIS_X);
            sy = pick_sample(AXIS_Y);
            advance_stamp();
            send_sample(sx, sy, stamp);
        end
    endtask

    // ------------------------------------------------------------------ tests

    task automatic test_reset_defaults();
        // full-scale tilt on both axes, age crossing both factor steps
        send_sample(16'sh8000, 16'sh7FFF, 32'd0);
        send_sample(16'sh8000, 16'sh7FFF, 32'd10);
        send_sample(16'sh8000, 16'sh7FFF, 32'd50);
        settle();
    endtask

    task automatic test_zone_edges();
        send_sample(16'sd999,  -16'sd999,  32'd200);
        send_sample(16'sd1000, -16'sd1000, 32'd201);
        send_sample(16'sd3000, -16'sd3000, 32'd202);
        send_sample(16'sd3001, -16'sd3001, 32'd203);
        send_sample(16'sd8000, -16'sd8000, 32'd204);
        send_sample(16'sd8001, -16'sd8001, 32'd205);
        send_sample(16'sd0,    -16'sd1,    32'd206);
        settle();
    endtask

    task automatic test_zone_age();
        send_sample(-16'sd20000, 16'sd20000, 32'd300);
        send_sample(-16'sd20000, 16'sd20000, 32'd309);
        send_sample(-16'sd20000, 16'sd20000, 32'd310);
        send_sample(-16'sd20000, 16'sd20000, 32'd349);
        send_sample(-16'sd20000, 16'sd20000, 32'd350);
        // zone begins just below the wrap of the millisecond count
        send_sample(16'sd4000, 16'sd0, 32'hFFFF_FFFB);
        send_sample(16'sd4000, 16'sd0, 32'd5);
        send_sample(16'sd4000, 16'sd0, 32'd45);
        // leaving the zone and coming back restarts its age
        send_sample(16'sd0,    16'sd0, 32'd60);
        send_sample(16'sd4000, 16'sd0, 32'd61);
        settle();
    endtask

    task automatic test_extreme_settings();
        write_reg(REG_DEAD_ZONE,        '0);
        write_reg(REG_SLIGHT_THRESHOLD, '0);
        write_reg(REG_STRONG_THRESHOLD, '0);
        write_reg(REG_SLIGHT_SPEED,     16'd31);
        write_reg(REG_STRONG_SPEED,     16'd31);
        write_reg(REG_DOUBLE_AFTER_MS,  '0);
        write_reg(REG_TRIPLE_AFTER_MS,  '0);
        cfg_valid <= 1'b0;
        send_sample(16'sd1,     16'sh8000, 32'd500);
        send_sample(16'sd0,     16'sd0,    32'd501);
        send_sample(-16'sd1,    16'sd1,    32'd502);
        settle();
        // all ones in every register, then a write to an index with no register
        write_reg(REG_DEAD_ZONE,        16'hFFFF);
        write_reg(REG_SLIGHT_THRESHOLD, 16'hFFFF);
        write_reg(REG_STRONG_THRESHOLD, 16'hFFFF);
        write_reg(REG_SLIGHT_SPEED,     16'hFFFF);
        write_reg(REG_STRONG_SPEED,     16'hFFFF);
        write_reg(REG_DOUBLE_AFTER_MS,  16'hFFFF);
        write_reg(REG_TRIPLE_AFTER_MS,  16'hFFFF);
        write_reg(REG_UNMAPPED,         16'h0000);
        cfg_valid <= 1'b0;
        send_sample(16'sh8000, 16'sh7FFF,  32'd1000);
        send_sample(16'sh8000, -16'sd32767, 32'd1000 + 32'd65534);
        send_sample(16'sh8000, 16'sh7FFF,  32'd1000 + 32'd65535);
        settle();
    endtask

    task automatic test_random_settings();
        load_settings(CFG_RST);
        run_random(120);
        for (int round = 0; round < 4; round++)
        begin
            load_settings(rand_settings(round[0] == 1'b0));
            run_random(100);
        end
        settle();
    endtask

    task automatic test_quiet_stretch();
        load_settings(rand_settings(1'b1));
        quiet = 1'b1;
        run_random(100);
        settle();
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        load_settings(rand_settings(1'b1));
        // receiver holds off while the sender keeps offering transfers
        hold_left <= 300;
        run_random(80);
        settle();
    endtask

    initial
    begin
        live_cfg   = CFG_RST;
        axis_zone  = '{ZONE_NEUTRAL, ZONE_NEUTRAL};
        zone_start = '{'0, '0};
        held       = '{'0, '0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zone_edges();
        test_zone_age();
        test_extreme_settings();
        test_random_settings();
        test_quiet_stretch();
        test_backpressure();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[tilt_to_pointer_motion_core] OK");
        else
            $display("[tilt_to_pointer_motion_core] ERROR");
        $finish;
    end

endmodule
